>>> hw/rtl/ntc_pkg.sv
`default_nettype none
package ntc_pkg;

  localparam int QDEPTH = 2;

  // register indexes on the configuration channel
  localparam logic [1:0] CFG_BETA    = 2'd0;
  localparam logic [1:0] CFG_NOMINAL = 2'd1;
  localparam logic [1:0] CFG_DIVIDER = 2'd2;
  localparam logic [1:0] CFG_REF_MV  = 2'd3;

  localparam logic [13:0] BETA_RESET    = 14'd3435;
  localparam logic [19:0] NOMINAL_RESET = 20'd10000;
  localparam logic [19:0] DIVIDER_RESET = 20'd10000;
  localparam logic [12:0] REF_MV_RESET  = 13'd3300;

  localparam logic [11:0] MV_SCALE   = 12'd3300;
  localparam logic [16:0] ADC_FULL   = 17'd65535;
  localparam logic [37:0] LN2_Q16    = 38'd45426;
  localparam logic [37:0] LN_ROUND   = 38'd32768;
  localparam logic signed [38:0] T25_CENTI_K = 39'sd29815;
  localparam logic [35:0] NN_SCALE   = 36'd2981500;
  localparam logic [35:0] DIV100_MUL = 36'd167773;

  localparam logic signed [18:0] TEMP_MIN    = -19'sd27315;
  localparam logic signed [18:0] TEMP_CEIL   = 19'sd150000;
  localparam logic signed [18:0] T0_CENTI_K  = 19'sd27315;

  typedef struct packed {
    logic [13:0] beta;
    logic [19:0] nominal;
    logic [19:0] divider;
    logic [12:0] ref_mv;
  } cfg_t;

  typedef struct packed {
    logic        updated;
    logic [11:0] mv;
    logic        oor;
    logic        therm;
    logic        sel;
    logic        calc;
  } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ntc_if.sv
`default_nettype none
interface ntc_in_if import ntc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [15:0] raw_sample;
  modport source(output valid, channel, raw_sample, input ready);
  modport sink(input valid, channel, raw_sample, output ready);
endinterface

interface ntc_out_if import ntc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               updated;
  logic [11:0]        millivolts;
  logic signed [18:0] temperature_centi_c;
  logic               out_of_range;
  logic [10:0]        max_temp_c;
  modport source(output valid, updated, millivolts, temperature_centi_c, out_of_range,
                 max_temp_c, input ready);
  modport sink(input valid, updated, millivolts, temperature_centi_c, out_of_range,
               max_temp_c, output ready);
endinterface

interface ntc_cfg_if import ntc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/adc_ntc_temperature_converter.sv
// adc sample to ntc temperature converter
// sample channel: valid/ready, carries channel and a 16-bit raw_sample; accepted
//   whenever the two-entry command queue has room
// result channel: valid/ready, exactly one item per accepted sample, in order
// cfg channel: always ready; writes beta, nominal and divider resistance and the
//   reference voltage by index; the user must write only while no sample is in
//   flight, and the block itself does not enforce it
// path: a repeated sample, a version channel or an open/short input skips the log2
//   unit and divider; a thermistor sample that changed takes two passes through the
//   shared log2 unit (normalize plus 16 squaring steps each) and an 18-step restoring divider
// flow: one item at a time in the back end; the front end and queue keep taking up
//   to two items meanwhile
// reset: clears the stored samples and temperatures to zero and loads the default
//   register values; no result is pending after reset
// a stalled result holds on the port and the back end waits on it, then the queue
//   fills and sample ready drops
`default_nettype none
module adc_ntc_temperature_converter import ntc_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  ntc_in_if.sink    sample,
  ntc_out_if.source result,
  ntc_cfg_if.sink   cfg
);
  cfg_t cfg_regs;
  logic front_valid;
  cmd_t front_cmd;
  logic queue_ready;
  logic queue_valid;
  cmd_t queue_cmd;
  logic queue_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.beta    <= BETA_RESET;
      cfg_regs.nominal <= NOMINAL_RESET;
      cfg_regs.divider <= DIVIDER_RESET;
      cfg_regs.ref_mv  <= REF_MV_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BETA:    cfg_regs.beta    <= cfg.data[13:0];
        CFG_NOMINAL: cfg_regs.nominal <= cfg.data;
        CFG_DIVIDER: cfg_regs.divider <= cfg.data;
        CFG_REF_MV:  cfg_regs.ref_mv  <= cfg.data[12:0];
      endcase
    end
  end

  ntc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg       (cfg_regs),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (queue_ready)
  );

  ntc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .din       (front_cmd),
    .in_ready  (queue_ready),
    .pop       (queue_pop),
    .dout      (queue_cmd),
    .out_valid (queue_valid)
  );

  ntc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .cmd_valid (queue_valid),
    .cmd_in    (queue_cmd),
    .cmd_pop   (queue_pop),
    .result    (result)
  );
endmodule
`default_nettype wire

>>> hw/rtl/ntc_queue.sv
`default_nettype none
module ntc_queue import ntc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      din,
  output logic      in_ready,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      out_valid
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem [QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign in_ready  = (count != CW'(QDEPTH));
  assign out_valid = (count != '0);
  assign dout      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ntc_front.sv
`default_nettype none
module ntc_front import ntc_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  ntc_in_if.sink    sample,
  input  cfg_t      cfg,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_ready
);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0]   last_sample [CHANNELS];
  logic          accept;
  logic          in_range;
  logic [CW-1:0] idx;
  logic [27:0]   prod;
  logic [11:0]   q0;
  logic [16:0]   rem;
  logic [11:0]   mv;
  logic          changed;
  logic          therm;

  assign sample.ready = cmd_ready;
  assign accept       = sample.valid && cmd_ready;
  assign cmd_valid    = accept;

  assign in_range = (32'(sample.channel) < CHANNELS);
  assign idx      = CW'(sample.channel);
  assign therm    = in_range && (sample.channel == 2'd1 || sample.channel == 2'd2);

  // divide by 65535: quotient from the high half, one correction step
  assign prod = 28'(sample.raw_sample) * 28'(MV_SCALE);
  assign q0   = prod[27:16];
  assign rem  = 17'(prod[15:0]) + 17'(q0);
  assign mv   = (rem >= ADC_FULL) ? q0 + 12'd1 : q0;

  assign changed = in_range && (last_sample[idx] != sample.raw_sample);

  always_comb begin
    cmd.updated = changed;
    cmd.mv      = in_range ? mv : '0;
    cmd.therm   = therm;
    cmd.sel     = (sample.channel == 2'd2);
    cmd.oor     = therm && (mv == '0 || 13'(mv) >= cfg.ref_mv);
    cmd.calc    = therm && changed && !(mv == '0 || 13'(mv) >= cfg.ref_mv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_sample[i] <= '0;
      end
    end else if (accept && changed) begin
      last_sample[idx] <= sample.raw_sample;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ntc_log2.sv
`default_nettype none
module ntc_log2 import ntc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] x,
  output logic             done,
  output logic [21:0]      result
);
  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lstate_t;

  lstate_t     state;
  logic [33:0] y;
  logic [5:0]  k;
  logic [15:0] frac;
  logic [3:0]  cnt;
  logic [61:0] sq;
  logic [31:0] sq30;

  assign sq     = 62'(y[30:0]) * 62'(y[30:0]);
  assign sq30   = sq[61:30];
  assign result = {k, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == L_SQR) && (cnt == '0);
      unique case (state)
        L_IDLE: begin
          if (start) begin
            y     <= {1'b0, x};
            k     <= 6'd30;
            frac  <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          // bring the leading one to bit 30
          priority if (y[33:31] != '0) begin
            y <= y >> 1;
            k <= k + 6'd1;
          end else if (y[30:22] == '0) begin
            y <= y << 8;
            k <= k - 6'd8;
          end else if (!y[30]) begin
            y <= y << 1;
            k <= k - 6'd1;
          end else begin
            cnt   <= 4'd15;
            state <= L_SQR;
          end
        end
        L_SQR: begin
          if (sq30[31]) begin
            y         <= {3'b0, sq30[31:1]};
            frac[cnt] <= 1'b1;
          end else begin
            y <= {2'b0, sq30};
          end
          cnt <= cnt - 4'd1;
          if (cnt == '0) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ntc_back.sv
`default_nettype none
module ntc_back import ntc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic cmd_valid,
  input  cmd_t      cmd_in,
  output logic      cmd_pop,
  ntc_out_if.source result
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ZCHK, S_LOGN, S_LOGD, S_LN, S_PROD, S_DD, S_CHK, S_DIV, S_QT,
    S_FIN, S_OUT
  } bstate_t;

  bstate_t            state;
  cmd_t               cmd;
  logic [31:0]        num;
  logic [32:0]        den;
  logic [35:0]        nn;
  logic [20:0]        beta100;
  logic               log_start;
  logic [32:0]        log_x;
  logic               log_done;
  logic [21:0]        log_res;
  logic [21:0]        ln_n;
  logic [21:0]        ln_d;
  logic signed [22:0] dlog;
  logic [21:0]        mag;
  logic [21:0]        lnmag;
  logic               lneg;
  logic signed [38:0] lnv;
  logic signed [38:0] prod;
  logic signed [39:0] dd;
  logic [57:0]        num_r;
  logic [57:0]        rem;
  logic [57:0]        dsh;
  logic [17:0]        quo;
  logic [4:0]         cnt;
  logic signed [18:0] tq;
  logic signed [18:0] calc_temp;
  logic signed [18:0] stored [2];
  logic [17:0]        mx;
  logic [35:0]        mx_scaled;

  logic               res_valid;
  logic               res_updated;
  logic [11:0]        res_mv;
  logic signed [18:0] res_temp;
  logic               res_oor;
  logic [10:0]        res_max;

  ntc_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  assign dlog  = $signed({1'b0, ln_n}) - $signed({1'b0, ln_d});
  assign mag   = 22'(dlog[22] ? -dlog : dlog);
  assign lnv   = lneg ? -39'($signed({1'b0, lnmag})) : 39'($signed({1'b0, lnmag}));
  assign num_r = {6'b0, nn, 16'b0} + 58'({1'b0, dd[38:1]});
  assign tq    = $signed({1'b0, quo}) - T0_CENTI_K;

  // larger stored temperature floored at zero, then divided by 100
  always_comb begin
    mx = '0;
    if (stored[0] > $signed(19'(mx))) begin
      mx = 18'(stored[0]);
    end
    if (stored[1] > $signed({1'b0, mx})) begin
      mx = 18'(stored[1]);
    end
  end
  assign mx_scaled = 36'(mx) * DIV100_MUL;

  assign result.valid               = res_valid;
  assign result.updated             = res_updated;
  assign result.millivolts          = res_mv;
  assign result.temperature_centi_c = res_temp;
  assign result.out_of_range        = res_oor;
  assign result.max_temp_c          = res_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      log_start <= 1'b0;
      stored[0] <= '0;
      stored[1] <= '0;
    end else begin
      log_start <= (state == S_ZCHK && num != '0 && den != '0) ||
                   (state == S_LOGN && log_done);
      if (res_valid && result.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd       <= cmd_in;
            calc_temp <= TEMP_MIN;
            state     <= cmd_in.calc ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          num     <= 32'(cmd.mv) * 32'(cfg.divider);
          den     <= 33'(cfg.ref_mv - 13'(cmd.mv)) * 33'(cfg.nominal);
          nn      <= 36'(cfg.beta) * NN_SCALE;
          beta100 <= 21'(cfg.beta) * 21'd100;
          state   <= S_ZCHK;
        end
        S_ZCHK: begin
          if (num == '0 || den == '0) begin
            state <= S_FIN;
          end else begin
            log_x <= 33'(num);
            state <= S_LOGN;
          end
        end
        S_LOGN: begin
          if (log_done) begin
            ln_n  <= log_res;
            log_x <= den;
            state <= S_LOGD;
          end
        end
        S_LOGD: begin
          if (log_done) begin
            ln_d  <= log_res;
            state <= S_LN;
          end
        end
        S_LN: begin
          // ln = log2 * ln(2), rounded on the magnitude
          lnmag <= 22'((38'(mag) * LN2_Q16 + LN_ROUND) >> 16);
          lneg  <= dlog[22];
          state <= S_PROD;
        end
        S_PROD: begin
          prod  <= lnv * T25_CENTI_K;
          state <= S_DD;
        end
        S_DD: begin
          dd    <= $signed({3'b0, beta100, 16'b0}) + 40'(prod);
          state <= S_CHK;
        end
        S_CHK: begin
          if (dd <= 40'sd0 || num_r >= {1'b0, dd[38:0], 18'b0}) begin
            calc_temp <= TEMP_CEIL;
            state     <= S_FIN;
          end else begin
            rem   <= num_r;
            dsh   <= {1'b0, dd[38:0], 17'b0};
            quo   <= '0;
            cnt   <= 5'd17;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem      <= rem - dsh;
            quo[cnt] <= 1'b1;
          end
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            state <= S_QT;
          end
        end
        S_QT: begin
          calc_temp <= (tq > TEMP_CEIL) ? TEMP_CEIL : tq;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (cmd.therm && cmd.updated) begin
            stored[cmd.sel] <= calc_temp;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid   <= 1'b1;
            res_updated <= cmd.updated;
            res_mv      <= cmd.mv;
            res_temp    <= cmd.therm ? stored[cmd.sel] : '0;
            res_oor     <= cmd.oor;
            res_max     <= mx_scaled[34:24];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ntc_checker.sv
`default_nettype none
module ntc_checker import ntc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               updated,
  input wire logic [11:0]        millivolts,
  input wire logic signed [18:0] temperature_centi_c,
  input wire logic               out_of_range,
  input wire logic [10:0]        max_temp_c
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(temperature_centi_c) && $stable(millivolts))
    else $error("result changed while stalled");

  a_open_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range && updated |-> temperature_centi_c == TEMP_MIN)
    else $error("open or short input without minimum temperature");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> millivolts <= 12'd3300 && max_temp_c <= 11'd1500)
    else $error("result field out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind adc_ntc_temperature_converter ntc_checker u_ntc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (result.valid),
  .out_ready           (result.ready),
  .updated             (result.updated),
  .millivolts          (result.millivolts),
  .temperature_centi_c (result.temperature_centi_c),
  .out_of_range        (result.out_of_range),
  .max_temp_c          (result.max_temp_c)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ntc_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic               updated;
    logic [11:0]        mv;
    logic signed [18:0] temp;
    logic               oor;
    logic [10:0]        max_c;
  } reading_t;

  logic clk;
  logic rst;

  ntc_in_if  sample_bus();
  ntc_out_if result_bus();
  ntc_cfg_if cfg_bus();

  adc_ntc_temperature_converter #(.CHANNELS(3)) dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  // predictor copy of the block's registers and state
  logic [13:0] beta_k;
  logic [19:0] nominal_ohm;
  logic [19:0] divider_ohm;
  logic [12:0] ref_mv;
  logic [15:0] last_raw [3];
  int          therm_temp [2];

  reading_t expected_readings[$];
  int       mismatches;
  int       cycles;
  int       hold_left;
  bit       steady_rx;
  bit       steady_tx;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // log2 in q16: leading one, normalize to q30, then 16 squaring steps
  function automatic longint log2_q16(longint unsigned x);
    int unsigned    k;
    longint unsigned y;
    int unsigned    frac;
    k = 0;
    frac = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    if (k >= 30) y = x >> (k - 30);
    else y = x << (30 - k);
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | (32'd1 << i);
      end
    end
    return longint'(k) * 65536 + longint'(frac);
  endfunction

  function automatic int beta_temperature(int unsigned mv);
    longint unsigned num, den, mag;
    longint          d, lnv, dd, nn, t;
    num = longint'(mv) * divider_ohm;
    den = longint'(ref_mv - mv) * nominal_ohm;
    if (num == 0 || den == 0) return TEMP_MIN;
    d = log2_q16(num) - log2_q16(den);
    mag = (d < 0) ? -d : d;
    mag = (mag * 45426 + 32768) >> 16;
    lnv = (d < 0) ? -longint'(mag) : longint'(mag);
    dd = 64'sd100 * beta_k * 65536 + 64'sd29815 * lnv;
    if (dd <= 0) return TEMP_CEIL;
    nn = longint'(beta_k) * 29815 * 100 * 65536;
    t = (nn + dd / 2) / dd - 27315;
    if (t > 150000) t = 150000;
    if (t < -27315) t = -27315;
    return int'(t);
  endfunction

  function automatic reading_t predict_reading(logic [1:0] ch, logic [15:0] raw);
    reading_t r;
    int       mx;
    int       tmp;
    r = '0;
    tmp = 0;
    if (ch < 3) begin
      r.mv = 12'((32'(raw) * 3300) / 65535);
      if (last_raw[ch] != raw) begin
        r.updated = 1'b1;
        last_raw[ch] = raw;
      end
      if (ch == 1 || ch == 2) begin
        r.oor = (r.mv == 0 || r.mv >= ref_mv);
        if (r.updated)
          therm_temp[ch - 1] = r.oor ? -27315 : beta_temperature(r.mv);
        tmp = therm_temp[ch - 1];
      end
    end
    r.temp = tmp[18:0];
    mx = 0;
    if (therm_temp[0] > mx) mx = therm_temp[0];
    if (therm_temp[1] > mx) mx = therm_temp[1];
    r.max_c = 11'(mx / 100);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // result side: random stalls, plus a counted hold-off when requested
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
        if (!steady_rx) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        want = expected_readings.pop_front();
        if (result_bus.updated !== want.updated || result_bus.millivolts !== want.mv ||
            result_bus.temperature_centi_c !== want.temp ||
            result_bus.out_of_range !== want.oor || result_bus.max_temp_c !== want.max_c)
        begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: exp upd %0d mv %0d t %0d oor %0d max %0d",
                     cycles, want.updated, want.mv, want.temp, want.oor, want.max_c);
            $display("  got upd %0d mv %0d t %0d oor %0d max %0d",
                     result_bus.updated, result_bus.millivolts,
                     result_bus.temperature_centi_c, result_bus.out_of_range,
                     result_bus.max_temp_c);
          end
        end
      end
    end
  end

  task automatic send_sample(logic [1:0] ch, logic [15:0] raw);
    int gap;
    sample_bus.valid <= 1'b1;
    sample_bus.channel <= ch;
    sample_bus.raw_sample <= raw;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    expected_readings.push_back(predict_reading(ch, raw));
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [19:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_BETA:    beta_k = value[13:0];
      CFG_NOMINAL: nominal_ohm = value;
      CFG_DIVIDER: divider_ohm = value;
      CFG_REF_MV:  ref_mv = value[12:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(int b, int n, int d, int r);
    write_register(CFG_BETA, 20'(b));
    write_register(CFG_NOMINAL, 20'(n));
    write_register(CFG_DIVIDER, 20'(d));
    write_register(CFG_REF_MV, 20'(r));
  endtask

  task automatic test_directed();
    send_sample(2'd0, 16'd0);      // unchanged version sample
    send_sample(2'd1, 16'd0);      // unchanged thermistor, mv 0
    send_sample(2'd1, 16'hffff);   // full scale, open
    send_sample(2'd1, 16'h8000);
    send_sample(2'd1, 16'h8000);   // repeated sample keeps stored value
    send_sample(2'd2, 16'd1);      // rounds to 0 mv
    send_sample(2'd2, 16'd19);
    send_sample(2'd2, 16'd20);     // first nonzero mv
    send_sample(2'd2, 16'd65515);
    send_sample(2'd3, 16'hffff);   // channel out of range
    send_sample(2'd3, 16'd0);
    send_sample(2'd0, 16'h5555);
    send_sample(2'd0, 16'haaaa);
    send_sample(2'd0, 16'haaaa);
    send_sample(2'd1, 16'h0100);   // very hot
    send_sample(2'd2, 16'hff00);   // very cold
    send_sample(2'd1, 16'h0000);
    send_sample(2'd2, 16'h1234);
  endtask

  task automatic test_random(int count);
    logic [1:0]  ch;
    logic [15:0] raw;
    int          sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      ch = (sel < 2) ? 2'd0 : (sel < 3) ? 2'd3 : (sel < 11) ? 2'd1 : 2'd2;
      sel = $urandom_range(0, 19);
      if (sel < 3 && ch != 2'd3) raw = last_raw[ch];
      else if (sel < 4) raw = 16'($urandom_range(0, 25));
      else if (sel < 5) raw = 16'($urandom_range(65500, 65535));
      else raw = 16'($urandom);
      send_sample(ch, raw);
    end
  endtask

  // long receiver hold-off while items keep coming, then a full drain
  task automatic test_backpressure();
    steady_tx = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 10; i++) send_sample(2'($urandom_range(1, 2)), 16'($urandom));
    steady_tx = 1'b0;
    wait_drained();
  endtask

  task automatic test_steady_flow();
    steady_rx = 1'b1;
    steady_tx = 1'b1;
    test_random(30);
    steady_rx = 1'b0;
    steady_tx = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    hold_left = 0;
    steady_rx = 1'b0;
    steady_tx = 1'b0;
    beta_k = BETA_RESET;
    nominal_ohm = NOMINAL_RESET;
    divider_ohm = DIVIDER_RESET;
    ref_mv = REF_MV_RESET;
    foreach (last_raw[i]) last_raw[i] = '0;
    therm_temp[0] = 0;
    therm_temp[1] = 0;
    rst <= 1'b1;
    sample_bus.valid <= 1'b0;
    sample_bus.channel <= '0;
    sample_bus.raw_sample <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(120);
    test_backpressure();
    test_steady_flow();
    load_setting(1000, 1, 1000000, 5000);
    test_random(60);
    load_setting(10000, 1000000, 1, 1000);
    test_random(60);
    load_setting(16383, 20'hfffff, 20'hfffff, 8191);
    test_random(40);
    load_setting(3950, 0, 4700, 3300);     // zero nominal resistance
    test_random(20);
    load_setting(0, 4700, 0, 3300);        // zero divider and zero beta
    test_random(20);
    load_setting(0, 10000, 10000, 3300);   // zero beta, nonzero log term
    test_random(20);
    load_setting($urandom_range(1000, 10000), $urandom_range(1, 1000000),
                 $urandom_range(1, 1000000), $urandom_range(1000, 5000));
    test_random(RANDOM_ITEMS - 370);
    load_setting(BETA_RESET, NOMINAL_RESET, DIVIDER_RESET, REF_MV_RESET);
    test_random(20);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
